// ===== rtl/qte_pkg.sv =====
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies
package qte_pkg;

    localparam int unsigned QuatWidth     = 16;
    localparam int unsigned AccFrac       = 30;
    localparam int unsigned DefStages     = 16;
    localparam int unsigned DefAngleFrac  = 13;
    localparam int unsigned MaxStages     = 24;
    // cordic datapath width: operands reach about 2^32 and grow by 1.65
    localparam int unsigned CordW         = 38;
    localparam int unsigned AccW          = 34;
    localparam int unsigned YawWidth      = 16;
    localparam int unsigned PitchWidth    = 15;
    localparam int unsigned RollWidth     = 16;

    localparam logic signed [AccW-1:0] PiQ30     = 34'sd3373259426;
    localparam logic signed [AccW-1:0] HalfPiQ30 = 34'sd1686629713;
    localparam logic signed [AccW-1:0] OneQ30    = 34'sd1073741824;

    typedef logic signed [CordW-1:0] t_cord;
    typedef logic signed [AccW-1:0]  t_acc;

    typedef struct packed {
        t_cord x;
        t_cord y;
        t_acc  z;
        logic  zero;
    } t_cord_state;

    function automatic t_acc atan_entry(input int unsigned i);
        t_acc v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837830;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            default: v = t_acc'(34'sd1048576 >>> (i - 10));
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/qte_stream_if.sv =====
// valid/ready stream channel carrying a packed payload
// no dependencies
interface qte_stream_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/quaternion_to_euler_angles.sv =====
// top level: quaternion to zyx euler angles, fully pipelined
// depends on qte_pkg, qte_stream_if, qte_isqrt, qte_atan2
//
// usage
//   i_req carries one request: {quat_w, quat_x, quat_y, quat_z}, each signed
//   q1.15, w in the top bits. o_rsp returns {yaw_angle[15:0], pitch_angle[14:0],
//   roll_angle[15:0], pitch_clamped} in radians, by default q3.13 (pitch q2.13).
//   a request is taken at a rising edge with valid and ready both high.
// throughput and stages
//   one request per cycle while the output does not stall. the stages in order:
//   products, sums, clamp, square of the argument, the 31-stage square root
//   that feeds the pitch operand, operand register, fold, CORDIC_STAGES (at most
//   24) micro-rotations, rounding and the output register.
//   the square root pipeline sets the depth; yaw and roll ride alongside it.
// stall
//   the whole pipeline advances on one enable; when the receiver holds ready
//   low and the output holds a result, every stage freezes and ready drops,
//   so nothing is lost or repeated. a bubble at the output lets the pipe move.
// reset
//   clears only the valid bits; the datapath registers are not reset
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES   = DefStages,
    parameter int unsigned ANGLE_FRAC_BITS = DefAngleFrac
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qte_stream_if.sink   i_req,
    qte_stream_if.source o_rsp
);
    localparam int unsigned N   = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
    localparam int unsigned Lat = N + 39;

    logic en;
    logic [Lat-1:0] r_vld;

    assign en          = !r_vld[Lat-1] || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], i_req.valid};
        end
    end

    // stage 1: products
    logic signed [15:0] qw, qx, qy, qz;
    assign {qw, qx, qy, qz} = i_req.data[63:0];
    logic signed [31:0] r_ww, r_xx, r_zz, r_wz, r_xy, r_wx, r_yz, r_xz, r_wy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= qw * qw; r_xx <= qx * qx; r_zz <= qz * qz;
            r_wz <= qw * qz; r_xy <= qx * qy; r_wx <= qw * qx;
            r_yz <= qy * qz; r_xz <= qx * qz; r_wy <= qw * qy;
        end
    end

    // stage 2: operands
    t_cord r_yn, r_yd, r_rn, r_rd;
    logic signed [34:0] r_a;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yn <= (t_cord'(r_wz) + t_cord'(r_xy)) <<< 1;
            r_yd <= ((t_cord'(r_ww) + t_cord'(r_xx)) <<< 1) - t_cord'(OneQ30);
            r_rn <= (t_cord'(r_wx) + t_cord'(r_yz)) <<< 1;
            r_rd <= ((t_cord'(r_ww) + t_cord'(r_zz)) <<< 1) - t_cord'(OneQ30);
            r_a  <= (35'(r_wy) - 35'(r_xz)) <<< 1;
        end
    end

    // stage 3: clamp
    logic signed [31:0] r_ac;
    logic r_clamp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_a > 35'(OneQ30)) begin
                r_ac <= 32'(OneQ30); r_clamp <= 1'b1;
            end else if (r_a < -35'(OneQ30)) begin
                r_ac <= -32'(OneQ30); r_clamp <= 1'b1;
            end else begin
                r_ac <= r_a[31:0]; r_clamp <= 1'b0;
            end
        end
    end

    // stage 4: square of the argument, then the root
    // magnitude is at most 2^30, so the square is a 31 by 31 product
    logic [30:0] a_mag;
    logic [61:0] a_sq;
    assign a_mag = r_ac[31] ? 31'(-r_ac) : r_ac[30:0];
    assign a_sq  = a_mag * a_mag;

    logic [60:0] r_rad;
    logic signed [31:0] r_a4;
    logic r_clamp4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad    <= (61'd1 << 60) - a_sq[60:0];
            r_a4     <= r_ac;
            r_clamp4 <= r_clamp;
        end
    end

    logic [30:0] root;
    qte_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // delay lines alongside the square root and the pitch operand register
    localparam int unsigned Dl = 31;
    logic signed [31:0] r_ad [Dl];
    t_cord r_ynd [Dl+3], r_ydd [Dl+3], r_rnd [Dl+3], r_rdd [Dl+3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ad[0] <= r_a4;
            for (int k = 1; k < Dl; k++) r_ad[k] <= r_ad[k-1];
            r_ynd[0] <= r_yn; r_ydd[0] <= r_yd; r_rnd[0] <= r_rn; r_rdd[0] <= r_rd;
            for (int k = 1; k < Dl + 3; k++) begin
                r_ynd[k] <= r_ynd[k-1]; r_ydd[k] <= r_ydd[k-1];
                r_rnd[k] <= r_rnd[k-1]; r_rdd[k] <= r_rdd[k-1];
            end
        end
    end

    logic [Lat-5:0] r_cl;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl <= {r_cl[Lat-6:0], r_clamp4};
        end
    end

    // operand register for pitch
    t_cord r_pn, r_pd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pn <= t_cord'(r_ad[Dl-1]);
            r_pd <= t_cord'({1'b0, root});
        end
    end

    logic [YawWidth-1:0]   yaw;
    logic [PitchWidth-1:0] pitch;
    logic [RollWidth-1:0]  roll;

    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                .OUT_W(YawWidth), .LIMIT(PiQ30)) u_yaw (
        .i_clk (i_clk), .i_en (en), .i_num (r_ynd[Dl+2]), .i_den (r_ydd[Dl+2]),
        .o_angle (yaw)
    );
    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                .OUT_W(PitchWidth), .LIMIT(HalfPiQ30)) u_pitch (
        .i_clk (i_clk), .i_en (en), .i_num (r_pn), .i_den (r_pd),
        .o_angle (pitch)
    );
    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                .OUT_W(RollWidth), .LIMIT(PiQ30)) u_roll (
        .i_clk (i_clk), .i_en (en), .i_num (r_rnd[Dl+2]), .i_den (r_rdd[Dl+2]),
        .o_angle (roll)
    );

    assign o_rsp.valid = r_vld[Lat-1];
    assign o_rsp.data  = {yaw, pitch, roll, r_cl[Lat-5]};

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.data))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("ready low with empty output");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && o_rsp.ready |=> r_vld[0])
        else $error("accepted request not tracked");
`endif
endmodule

// ===== rtl/qte_cordic_stage.sv =====
// one registered cordic vectoring micro-rotation
// depends on qte_pkg
module qte_cordic_stage
    import qte_pkg::*;
#(
    parameter int unsigned STAGE = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cord_state i_s,
    output t_cord_state o_s
);
    t_cord_state r_s, n_s;

    always_comb begin
        n_s = i_s;
        if (!i_s.y[CordW-1]) begin
            n_s.x = i_s.x + (i_s.y >>> STAGE);
            n_s.y = i_s.y - (i_s.x >>> STAGE);
            n_s.z = i_s.z + atan_entry(STAGE);
        end else begin
            n_s.x = i_s.x - (i_s.y >>> STAGE);
            n_s.y = i_s.y + (i_s.x >>> STAGE);
            n_s.z = i_s.z - atan_entry(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;
endmodule

// ===== rtl/qte_isqrt.sv =====
// pipelined floor square root, one result bit per stage
// depends on qte_pkg
module qte_isqrt
    import qte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_rad,
    output logic [30:0] o_root
);
    localparam int unsigned Bits = 31;

    logic [61:0] r_rem  [Bits+1];
    logic [30:0] r_root [Bits+1];

    assign r_rem[0]  = {1'b0, i_rad};
    assign r_root[0] = '0;

    for (genvar g = 0; g < Bits; g++) begin : g_bit
        // result bit position decided in this stage
        localparam int unsigned P  = Bits - 1 - g;
        localparam int unsigned Sh = 2 * P;
        logic [61:0] trial;
        logic [61:0] n_rem;
        logic [30:0] n_root;
        logic [61:0] r_rem_q;
        logic [30:0] r_root_q;
        always_comb begin
            trial = (62'(r_root[g]) << (P + 1)) + (62'd1 << Sh);
            if (r_rem[g] >= trial) begin
                n_rem  = r_rem[g] - trial;
                n_root = r_root[g] | (31'd1 << P);
            end else begin
                n_rem  = r_rem[g];
                n_root = r_root[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_q  <= n_rem;
                r_root_q <= n_root;
            end
        end
        assign r_rem[g+1]  = r_rem_q;
        assign r_root[g+1] = r_root_q;
    end

    assign o_root = r_root[Bits];
endmodule

// ===== rtl/qte_atan2.sv =====
// cordic atan2 pipeline with quadrant fold, rounding and saturation
// depends on qte_pkg, qte_cordic_stage
module qte_atan2
    import qte_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES   = DefStages,
    parameter int unsigned ANGLE_FRAC_BITS = DefAngleFrac,
    parameter int unsigned OUT_W           = 16,
    parameter logic signed [AccW-1:0] LIMIT = PiQ30
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_cord            i_num,
    input  t_cord            i_den,
    output logic [OUT_W-1:0] o_angle
);
    localparam int unsigned Sh = AccFrac - ANGLE_FRAC_BITS;
    localparam int unsigned N  = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
    localparam t_acc Half = t_acc'(1) <<< (Sh - 1);
    localparam t_acc Lim  = (LIMIT + Half) >>> Sh;

    t_cord_state r_fold;
    t_cord_state s [N+1];
    t_acc        r_rnd;
    logic        r_zero;
    logic [OUT_W-1:0] r_out;
    t_acc        sum_q;
    t_acc        sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold.zero <= (i_num == '0) && (i_den == '0);
            if (i_den[CordW-1]) begin
                r_fold.x <= -i_den;
                r_fold.y <= -i_num;
                r_fold.z <= i_num[CordW-1] ? -PiQ30 : PiQ30;
            end else begin
                r_fold.x <= i_den;
                r_fold.y <= i_num;
                r_fold.z <= '0;
            end
        end
    end

    assign s[0] = r_fold;
    for (genvar g = 0; g < N; g++) begin : g_stage
        t_cord_state st_in, st_out;
        assign st_in = s[g];
        qte_cordic_stage #(.STAGE(g)) u_stage (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_s   (st_in),
            .o_s   (st_out)
        );
        assign s[g+1] = st_out;
    end

    assign sum_q = (s[N].z + Half) >>> Sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd  <= sum_q;
            r_zero <= s[N].zero;
        end
    end

    always_comb begin
        if (r_zero) begin
            sat = '0;
        end else if (r_rnd > Lim) begin
            sat = Lim;
        end else if (r_rnd < -Lim) begin
            sat = -Lim;
        end else begin
            sat = r_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= sat[OUT_W-1:0];
        end
    end

    assign o_angle = r_out;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for quaternion_to_euler_angles: directed and random quaternions
// checked against a fixed-point cordic predictor; depends on qte_pkg, qte_stream_if
module testbench;
    import qte_pkg::*;

    localparam int unsigned ReqW = 4 * QuatWidth;
    localparam int unsigned RspW = YawWidth + PitchWidth + RollWidth + 1;
    localparam longint PiQ = 64'sd3373259426;
    localparam longint HalfPiQ = 64'sd1686629713;
    localparam longint OneQ = 64'sd1073741824;
    localparam int unsigned Stages = DefStages;
    localparam int unsigned Frac = DefAngleFrac;
    localparam int unsigned Latency = Stages + 39;
    localparam longint CycleLimit = 400000;

    typedef struct packed {
        logic [YawWidth-1:0]   yaw;
        logic [PitchWidth-1:0] pitch;
        logic [RollWidth-1:0]  roll;
        logic                  clamped;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qte_stream_if #(.W(ReqW)) req_if ();
    qte_stream_if #(.W(RspW)) rsp_if ();

    quaternion_to_euler_angles uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always #10 i_clk = ~i_clk;

    t_angles angles_due[$];
    int      error_count = 0;
    longint  cycle_count = 0;
    bit      hold_off = 1'b0;
    int      burst_left = 0;

    // -------- angle predictor --------
    function automatic longint shr_floor(longint v, int unsigned s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(longint num, longint den);
        longint x, y, z, xs, ys;
        x = den;
        y = num;
        z = 0;
        if (x == 0 && y == 0) return 0;
        // left half plane: fold and start from plus or minus pi
        if (x < 0) begin
            z = (y >= 0) ? PiQ : -PiQ;
            x = -x;
            y = -y;
        end
        for (int unsigned i = 0; i < Stages; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(i));
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(i));
            end
        end
        return z;
    endfunction

    function automatic longint round_sat(longint z, longint lim_q);
        longint half, r, lim;
        half = longint'(1) << (AccFrac - Frac - 1);
        r = shr_floor(z + half, AccFrac - Frac);
        lim = shr_floor(lim_q + half, AccFrac - Frac);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic t_angles predict_angles(logic [ReqW-1:0] q);
        longint w, x, y, z, a, c;
        t_angles r;
        w = longint'($signed(q[63:48]));
        x = longint'($signed(q[47:32]));
        y = longint'($signed(q[31:16]));
        z = longint'($signed(q[15:0]));
        a = -2 * (x * z - w * y);
        r.clamped = 1'b0;
        // asin argument beyond unit magnitude is clamped and flagged
        if (a > OneQ) begin
            a = OneQ;
            r.clamped = 1'b1;
        end
        if (a < -OneQ) begin
            a = -OneQ;
            r.clamped = 1'b1;
        end
        c = floor_sqrt((64'd1 << 60) - longint'(a * a));
        r.yaw = YawWidth'(round_sat(cordic_angle(2 * (w * z + x * y),
                2 * (w * w + x * x) - OneQ), PiQ));
        r.pitch = PitchWidth'(round_sat(cordic_angle(a, c), HalfPiQ));
        r.roll = RollWidth'(round_sat(cordic_angle(2 * (w * x + y * z),
                2 * (w * w + z * z) - OneQ), PiQ));
        return r;
    endfunction

    // -------- request driver --------
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
            logic [15:0] z);
        logic [ReqW-1:0] q;
        q = {w, x, y, z};
        // bursts with random gaps between them
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data <= q;
        angles_due.push_back(predict_angles(q));
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (burst_left == 0) req_if.valid <= 1'b0;
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // unit quaternion from random angles, scaled to q1.15 with small error
    task automatic send_unit_quat();
        real a, b, g, n;
        real qw, qx, qy, qz;
        a = ($urandom_range(0, 65535) / 65535.0) * 6.2832;
        b = ($urandom_range(0, 65535) / 65535.0) * 6.2832;
        g = ($urandom_range(0, 65535) / 65535.0) * 6.2832;
        qw = $cos(a) * $cos(b);
        qx = $sin(a) * $cos(g);
        qy = $cos(a) * $sin(b);
        qz = $sin(a) * $sin(g);
        n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz) * 1.0002;
        send_quat(16'(int'(qw / n * 32767.0)), 16'(int'(qx / n * 32767.0)),
                16'(int'(qy / n * 32767.0)), 16'(int'(qz / n * 32767.0)));
    endtask

    // -------- tests --------
    task automatic test_directed();
        send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000); // zero quaternion
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000); // left half plane
        send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
        send_quat(16'h5a82, 16'h0000, 16'h5a82, 16'h0000); // pitch at +90
        send_quat(16'h5a82, 16'h0000, 16'ha57e, 16'h0000); // pitch at -90
        send_quat(16'h7fff, 16'h0000, 16'h7fff, 16'h0000); // asin clamp high
        send_quat(16'h7fff, 16'h0000, 16'h8000, 16'h0000); // asin clamp low
        send_quat(16'h0000, 16'h7fff, 16'h7fff, 16'h0000);
        send_quat(16'h0000, 16'h5a82, 16'h0000, 16'h5a82);
        send_quat(16'h5a82, 16'h5a82, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h5a82, 16'h5a82, 16'h0000);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0) send_unit_quat();
            else send_quat(rnd16(), rnd16(), rnd16(), rnd16());
        end
    endtask

    // long receiver hold-off while requests keep coming, fills the pipe
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(120);
        hold_off = 1'b0;
    endtask

    // -------- receiver stall pattern and hold-off --------
    int stall_phase = 0;
    int hold_cycles = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 37;
        if (hold_off && hold_cycles < 300) hold_cycles <= hold_cycles + 1;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_off && hold_cycles < 300) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_phase < 12) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // -------- result checker --------
    always @(posedge i_clk) begin
        t_angles got, want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (angles_due.size() == 0) begin
                $display("%0t: result with none due, actual %h", $time, got);
                error_count++;
            end else begin
                want = angles_due.pop_front();
                if (got.yaw !== want.yaw) begin
                    $display("%0t: yaw expected %h actual %h", $time, want.yaw, got.yaw);
                    error_count++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch expected %h actual %h", $time, want.pitch,
                            got.pitch);
                    error_count++;
                end
                if (got.roll !== want.roll) begin
                    $display("%0t: roll expected %h actual %h", $time, want.roll,
                            got.roll);
                    error_count++;
                end
                if (got.clamped !== want.clamped) begin
                    $display("%0t: clamp expected %b actual %b", $time, want.clamped,
                            got.clamped);
                    error_count++;
                end
            end
        end
        if (cycle_count > CycleLimit) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1410);
        // the driver leaves valid high if its burst has not ended; drop it here
        if (burst_left != 0) req_if.valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
